### src/rra_pkg.sv
// rra_pkg: shared constants, types and the coverage table for the
// rounded rectangle pixel shader; no dependencies
package rra_pkg;

	// field widths
	localparam int COORD_BITS     = 13;
	localparam int SUBSAMPLE_GRID = 4;
	localparam int DIM_BITS       = 12;
	localparam int RAD_BITS       = DIM_BITS - 1;
	localparam int RGB_BITS       = 24;
	localparam int CH_BITS        = 8;
	localparam int CH_COUNT       = RGB_BITS / CH_BITS;

	// register port
	localparam int DATA_BITS = 32;
	localparam int ADDR_BITS = 5;
	localparam int IDX_BITS  = ADDR_BITS - 2;

	// derived datapath widths
	localparam int SUB_COUNT  = SUBSAMPLE_GRID * SUBSAMPLE_GRID;
	localparam int GRID_BITS  = $clog2(SUBSAMPLE_GRID);
	localparam int CNT_BITS   = $clog2(SUB_COUNT + 1);
	localparam int CMP_BITS   = ((COORD_BITS > DIM_BITS) ? COORD_BITS : DIM_BITS) + 2;
	localparam int DELTA_BITS = RAD_BITS + 1;
	localparam int MAG_BITS   = RAD_BITS + GRID_BITS;
	localparam int SUB_BITS   = MAG_BITS + 1;
	localparam int SQ_BITS    = 2 * MAG_BITS;
	localparam int SUM_BITS   = SQ_BITS + 1;
	localparam int PROD_BITS  = 2 * CH_BITS + 1;

	localparam logic [CH_BITS-1:0] COV_FULL = '1;

	// register indexes
	typedef enum logic [IDX_BITS-1:0] {
		REG_LEFT     = 3'd0,
		REG_TOP      = 3'd1,
		REG_WIDTH    = 3'd2,
		REG_HEIGHT   = 3'd3,
		REG_RADIUS   = 3'd4,
		REG_FILL     = 3'd5,
		REG_BACKDROP = 3'd6
	} reg_idx_t;

	// how a pixel is shaded as it moves down the pipe
	typedef enum logic [1:0] {
		SHADE_SKIP,
		SHADE_FILL,
		SHADE_CORNER,
		SHADE_BLEND
	} shade_t;

	// configuration as seen by the datapath, radius already clamped
	typedef struct packed {
		logic [COORD_BITS-1:0] left;
		logic [COORD_BITS-1:0] top;
		logic [DIM_BITS-1:0]   width;
		logic [DIM_BITS-1:0]   height;
		logic [RAD_BITS-1:0]   radius;
		logic [RGB_BITS-1:0]   fill;
		logic [RGB_BITS-1:0]   backdrop;
	} cfg_t;

	// geometry result: class and pixel offset from the corner center
	typedef struct packed {
		shade_t                shade;
		logic [DELTA_BITS-1:0] dx;
		logic [DELTA_BITS-1:0] dy;
	} geo_t;

	// coverage result
	typedef struct packed {
		shade_t              shade;
		logic [CH_BITS-1:0]  cov;
	} shd_t;

	// sample count to 8-bit coverage, cnt*255/SUB_COUNT truncated
	function automatic logic [CH_BITS-1:0] cov_of(input logic [CNT_BITS-1:0] cnt);
		logic [CH_BITS-1:0] res;
		res = '0;
		for (int k = 0; k <= SUB_COUNT; k++) begin
			if (cnt == CNT_BITS'(k))
				res = CH_BITS'((k * 255) / SUB_COUNT);
		end
		return res;
	endfunction

endpackage

### src/rra_cfg.sv
// rra_cfg: register file behind the APB-style port, plus radius clamp
// depends on rra_pkg
module rra_cfg (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           psel,
	input  logic                           penable,
	input  logic                           pwrite,
	input  logic [rra_pkg::ADDR_BITS-1:0]  paddr,
	input  logic [rra_pkg::DATA_BITS-1:0]  pwdata,
	output logic [rra_pkg::DATA_BITS-1:0]  prdata,
	output logic                           pready,
	output rra_pkg::cfg_t                  cfg
);

	logic [rra_pkg::COORD_BITS-1:0] left_q;
	logic [rra_pkg::COORD_BITS-1:0] top_q;
	logic [rra_pkg::DIM_BITS-1:0]   width_q;
	logic [rra_pkg::DIM_BITS-1:0]   height_q;
	logic [rra_pkg::RAD_BITS-1:0]   radius_q;
	logic [rra_pkg::RGB_BITS-1:0]   fill_q;
	logic [rra_pkg::RGB_BITS-1:0]   backdrop_q;
	logic [rra_pkg::RAD_BITS-1:0]   rad_q;
	logic [rra_pkg::RAD_BITS-1:0]   rad_w;
	logic [rra_pkg::RAD_BITS-1:0]   rad_h;
	rra_pkg::reg_idx_t              idx;
	logic                           wr;

	assign pready = 1'b1;
	assign idx    = rra_pkg::reg_idx_t'(paddr[rra_pkg::ADDR_BITS-1:2]);
	assign wr     = psel && penable && pwrite;

	// register writes, unknown indexes dropped
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			left_q     <= '0;
			top_q      <= '0;
			width_q    <= '0;
			height_q   <= '0;
			radius_q   <= '0;
			fill_q     <= '0;
			backdrop_q <= '0;
		end else if (wr) begin
			case (idx)
				rra_pkg::REG_LEFT:     left_q     <= pwdata[rra_pkg::COORD_BITS-1:0];
				rra_pkg::REG_TOP:      top_q      <= pwdata[rra_pkg::COORD_BITS-1:0];
				rra_pkg::REG_WIDTH:    width_q    <= pwdata[rra_pkg::DIM_BITS-1:0];
				rra_pkg::REG_HEIGHT:   height_q   <= pwdata[rra_pkg::DIM_BITS-1:0];
				rra_pkg::REG_RADIUS:   radius_q   <= pwdata[rra_pkg::RAD_BITS-1:0];
				rra_pkg::REG_FILL:     fill_q     <= pwdata[rra_pkg::RGB_BITS-1:0];
				rra_pkg::REG_BACKDROP: backdrop_q <= pwdata[rra_pkg::RGB_BITS-1:0];
				default: ;
			endcase
		end
	end

	// read mux
	always_comb begin
		case (idx)
			rra_pkg::REG_LEFT:     prdata = rra_pkg::DATA_BITS'(left_q);
			rra_pkg::REG_TOP:      prdata = rra_pkg::DATA_BITS'(top_q);
			rra_pkg::REG_WIDTH:    prdata = rra_pkg::DATA_BITS'(width_q);
			rra_pkg::REG_HEIGHT:   prdata = rra_pkg::DATA_BITS'(height_q);
			rra_pkg::REG_RADIUS:   prdata = rra_pkg::DATA_BITS'(radius_q);
			rra_pkg::REG_FILL:     prdata = rra_pkg::DATA_BITS'(fill_q);
			rra_pkg::REG_BACKDROP: prdata = rra_pkg::DATA_BITS'(backdrop_q);
			default:               prdata = '0;
		endcase
	end

	// clamp radius to half width, then half height
	assign rad_w = ({radius_q, 1'b0} > width_q) ? width_q[rra_pkg::DIM_BITS-1:1] : radius_q;
	assign rad_h = ({rad_w, 1'b0} > height_q) ? height_q[rra_pkg::DIM_BITS-1:1] : rad_w;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			rad_q <= '0;
		else
			rad_q <= rad_h;
	end

	assign cfg.left     = left_q;
	assign cfg.top      = top_q;
	assign cfg.width    = width_q;
	assign cfg.height   = height_q;
	assign cfg.radius   = rad_q;
	assign cfg.fill     = fill_q;
	assign cfg.backdrop = backdrop_q;

endmodule

### src/rra_geom.sv
// rra_geom: stages 1-2, offsets into the rectangle and pixel class
// depends on rra_pkg
module rra_geom (
	input  logic                            clk,
	input  logic                            arst_n,
	input  rra_pkg::cfg_t                   cfg,
	input  logic                            in_valid,
	input  logic [rra_pkg::COORD_BITS-1:0]  pixel_x,
	input  logic [rra_pkg::COORD_BITS-1:0]  pixel_y,
	input  logic                            en_out,
	output logic                            en_in,
	output logic                            v_out,
	output rra_pkg::geo_t                   geo
);

	localparam int CB = rra_pkg::CMP_BITS;
	localparam int XB = rra_pkg::COORD_BITS;

	logic                 v_s1, v_s2;
	logic                 en_s1, en_s2;
	logic signed [CB-1:0] i_s1, j_s1;
	rra_pkg::geo_t        geo_s2;

	logic signed [CB-1:0] xe, ye, le, te;
	logic signed [CB-1:0] wc, hc, rc, dxw, dyw;
	logic                 in_rect, top_b, bot_b, lft_b, rgt_b, solid;
	rra_pkg::geo_t        geo_nx;

	// stage enables, bubbles squeeze out
	assign en_s2 = !v_s2 || en_out;
	assign en_s1 = !v_s1 || en_s2;
	assign en_in = en_s1;

	// sign-extend coordinates
	assign xe = $signed({{(CB - XB){pixel_x[XB-1]}}, pixel_x});
	assign ye = $signed({{(CB - XB){pixel_y[XB-1]}}, pixel_y});
	assign le = $signed({{(CB - XB){cfg.left[XB-1]}}, cfg.left});
	assign te = $signed({{(CB - XB){cfg.top[XB-1]}}, cfg.top});

	// stage 1: pixel offset from the top left corner
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			v_s1 <= 1'b0;
		else if (en_s1)
			v_s1 <= in_valid;
	end

	always_ff @(posedge clk) begin
		if (en_s1 && in_valid) begin
			i_s1 <= xe - le;
			j_s1 <= ye - te;
		end
	end

	// classify the pixel and find its offset from the corner center
	always_comb begin
		wc = $signed({{(CB - rra_pkg::DIM_BITS){1'b0}}, cfg.width});
		hc = $signed({{(CB - rra_pkg::DIM_BITS){1'b0}}, cfg.height});
		rc = $signed({{(CB - rra_pkg::RAD_BITS){1'b0}}, cfg.radius});
		in_rect = (i_s1 >= 0) && (j_s1 >= 0) && (i_s1 < wc) && (j_s1 < hc);
		top_b   = j_s1 < rc;
		bot_b   = j_s1 >= hc - rc;
		lft_b   = i_s1 < rc;
		rgt_b   = i_s1 >= wc - rc;
		solid   = (rc == 0) || !(top_b || bot_b) || (!lft_b && !rgt_b);
		dxw     = lft_b ? (i_s1 - rc) : (i_s1 - (wc - rc));
		dyw     = top_b ? (j_s1 - rc) : (j_s1 - (hc - rc));
		if (!in_rect)
			geo_nx.shade = rra_pkg::SHADE_SKIP;
		else if (solid)
			geo_nx.shade = rra_pkg::SHADE_FILL;
		else
			geo_nx.shade = rra_pkg::SHADE_CORNER;
		geo_nx.dx = dxw[rra_pkg::DELTA_BITS-1:0];
		geo_nx.dy = dyw[rra_pkg::DELTA_BITS-1:0];
	end

	// stage 2
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			v_s2 <= 1'b0;
		else if (en_s2)
			v_s2 <= v_s1;
	end

	always_ff @(posedge clk) begin
		if (en_s2 && v_s1)
			geo_s2 <= geo_nx;
	end

	assign v_out = v_s2;
	assign geo   = geo_s2;

endmodule

### src/rra_cover.sv
// rra_cover: stages 3-5, supersampled inside-circle test and coverage
// depends on rra_pkg
module rra_cover (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic [rra_pkg::RAD_BITS-1:0]  radius,
	input  logic                          v_in,
	input  rra_pkg::geo_t                 geo,
	input  logic                          en_out,
	output logic                          en_in,
	output logic                          v_out,
	output rra_pkg::shd_t                 shd
);

	localparam int G  = rra_pkg::SUBSAMPLE_GRID;
	localparam int SB = rra_pkg::SUB_BITS;
	localparam int MB = rra_pkg::MAG_BITS;
	localparam int QB = rra_pkg::SQ_BITS;
	localparam int DB = rra_pkg::DELTA_BITS;
	localparam logic signed [SB-1:0] GRID_S = SB'(G);

	logic                    v_s3, v_s4, v_s5;
	logic                    en_s3, en_s4, en_s5;
	rra_pkg::shade_t         shade_s3, shade_s4;
	logic [QB-1:0]           dxsq_s3 [G];
	logic [QB-1:0]           dysq_s3 [G];
	logic [QB-1:0]           rsq_s3;
	logic [rra_pkg::SUB_COUNT-1:0] hit_s4;
	rra_pkg::shd_t           shd_s5;

	logic signed [SB-1:0]    dxe, dye, sxv, syv;
	logic [MB-1:0]           mx [G];
	logic [MB-1:0]           my [G];
	logic [MB-1:0]           rg;
	logic [rra_pkg::SUB_COUNT-1:0] hit_nx;
	logic [rra_pkg::CNT_BITS-1:0]  cnt;
	logic [rra_pkg::CH_BITS-1:0]   cov;
	rra_pkg::shd_t           shd_nx;

	assign en_s5 = !v_s5 || en_out;
	assign en_s4 = !v_s4 || en_s5;
	assign en_s3 = !v_s3 || en_s4;
	assign en_in = en_s3;

	// subsample offsets in 1/G pixel units, as magnitudes
	always_comb begin
		dxe = $signed({{(SB - DB){geo.dx[DB-1]}}, geo.dx});
		dye = $signed({{(SB - DB){geo.dy[DB-1]}}, geo.dy});
		for (int k = 0; k < G; k++) begin
			sxv   = dxe * GRID_S + SB'(k);
			syv   = dye * GRID_S + SB'(k);
			mx[k] = sxv[SB-1] ? MB'(-sxv) : MB'(sxv);
			my[k] = syv[SB-1] ? MB'(-syv) : MB'(syv);
		end
		rg = MB'(radius) * MB'(G);
	end

	// stage 3: squares of the subsample offsets and of the scaled radius
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			v_s3 <= 1'b0;
		else if (en_s3)
			v_s3 <= v_in;
	end

	always_ff @(posedge clk) begin
		if (en_s3 && v_in) begin
			shade_s3 <= geo.shade;
			for (int k = 0; k < G; k++) begin
				dxsq_s3[k] <= QB'(mx[k]) * QB'(mx[k]);
				dysq_s3[k] <= QB'(my[k]) * QB'(my[k]);
			end
			rsq_s3 <= QB'(rg) * QB'(rg);
		end
	end

	// inside test per subsample, points on the circle count
	always_comb begin
		for (int sy = 0; sy < G; sy++) begin
			for (int sx = 0; sx < G; sx++) begin
				hit_nx[sy * G + sx] = (rra_pkg::SUM_BITS'(dxsq_s3[sx])
					+ rra_pkg::SUM_BITS'(dysq_s3[sy])) <= rra_pkg::SUM_BITS'(rsq_s3);
			end
		end
	end

	// stage 4: hit mask
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			v_s4 <= 1'b0;
		else if (en_s4)
			v_s4 <= v_s3;
	end

	always_ff @(posedge clk) begin
		if (en_s4 && v_s3) begin
			shade_s4 <= shade_s3;
			hit_s4   <= hit_nx;
		end
	end

	// count hits, map to coverage, settle the corner class
	always_comb begin
		cnt = rra_pkg::CNT_BITS'($countones(hit_s4));
		cov = rra_pkg::cov_of(cnt);
		shd_nx.cov = cov;
		case (shade_s4)
			rra_pkg::SHADE_CORNER: begin
				if (cov == rra_pkg::COV_FULL)
					shd_nx.shade = rra_pkg::SHADE_FILL;
				else if (cov != '0)
					shd_nx.shade = rra_pkg::SHADE_BLEND;
				else
					shd_nx.shade = rra_pkg::SHADE_SKIP;
			end
			default: shd_nx.shade = shade_s4;
		endcase
	end

	// stage 5
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			v_s5 <= 1'b0;
		else if (en_s5)
			v_s5 <= v_s4;
	end

	always_ff @(posedge clk) begin
		if (en_s5 && v_s4)
			shd_s5 <= shd_nx;
	end

	assign v_out = v_s5;
	assign shd   = shd_s5;

endmodule

### src/rra_blend.sv
// rra_blend: stages 6-7, per-channel blend of background toward fill
// and the output register; depends on rra_pkg
module rra_blend (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic [rra_pkg::RGB_BITS-1:0]  fill,
	input  logic [rra_pkg::RGB_BITS-1:0]  backdrop,
	input  logic                          v_in,
	input  rra_pkg::shd_t                 shd,
	input  logic                          en_out,
	output logic                          en_in,
	output logic                          v_out,
	output logic                          draw,
	output logic [rra_pkg::RGB_BITS-1:0]  pixel_rgb
);

	localparam int CB = rra_pkg::CH_BITS;
	localparam int PB = rra_pkg::PROD_BITS;
	localparam int NC = rra_pkg::CH_COUNT;

	logic                 v_s6, v_s7;
	logic                 en_s6, en_s7;
	rra_pkg::shade_t      shade_s6;
	logic [CB-1:0]        bg_s6 [NC];
	logic signed [PB-1:0] prod_s6 [NC];
	logic                 draw_s7;
	logic [rra_pkg::RGB_BITS-1:0] rgb_s7;

	logic signed [CB:0]     diff;
	logic signed [CB:0]     covs;
	logic signed [2*CB+1:0] prod_w;
	logic signed [PB-1:0]   prod_nx [NC];
	logic signed [PB-1:0]   neg_p;
	logic [PB-2:0]          mag;
	logic [PB-1:0]          q_w;
	logic [CB-1:0]          q;
	logic [rra_pkg::RGB_BITS-1:0] mix;

	assign en_s7 = !v_s7 || en_out;
	assign en_s6 = !v_s6 || en_s7;
	assign en_in = en_s6;

	// (fg - bg) * cov per channel
	always_comb begin
		covs = $signed({1'b0, shd.cov});
		for (int c = 0; c < NC; c++) begin
			diff = $signed({1'b0, fill[c*CB +: CB]}) - $signed({1'b0, backdrop[c*CB +: CB]});
			prod_w = diff * covs;
			prod_nx[c] = prod_w[PB-1:0];
		end
	end

	// stage 6
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			v_s6 <= 1'b0;
		else if (en_s6)
			v_s6 <= v_in;
	end

	always_ff @(posedge clk) begin
		if (en_s6 && v_in) begin
			shade_s6 <= shd.shade;
			for (int c = 0; c < NC; c++) begin
				bg_s6[c]   <= backdrop[c*CB +: CB];
				prod_s6[c] <= prod_nx[c];
			end
		end
	end

	// divide by 255 toward zero, add to background
	always_comb begin
		mix = '0;
		for (int c = 0; c < NC; c++) begin
			neg_p = -prod_s6[c];
			mag   = prod_s6[c][PB-1] ? neg_p[PB-2:0] : prod_s6[c][PB-2:0];
			q_w   = {1'b0, mag} + PB'(mag >> CB) + PB'(1);
			q     = q_w[2*CB-1:CB];
			mix[c*CB +: CB] = prod_s6[c][PB-1] ? (bg_s6[c] - q) : (bg_s6[c] + q);
		end
	end

	// stage 7: output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			v_s7 <= 1'b0;
		else if (en_s7)
			v_s7 <= v_s6;
	end

	always_ff @(posedge clk) begin
		if (en_s7 && v_s6) begin
			case (shade_s6)
				rra_pkg::SHADE_FILL: begin
					draw_s7 <= 1'b1;
					rgb_s7  <= fill;
				end
				rra_pkg::SHADE_BLEND: begin
					draw_s7 <= 1'b1;
					rgb_s7  <= mix;
				end
				default: begin
					draw_s7 <= 1'b0;
					rgb_s7  <= '0;
				end
			endcase
		end
	end

	assign v_out     = v_s7;
	assign draw      = draw_s7;
	assign pixel_rgb = rgb_s7;

endmodule

### src/rounded_rect_aa_pixel_shader.sv
// rounded_rect_aa_pixel_shader: top level; uses rra_pkg, rra_cfg, rra_geom,
// rra_cover and rra_blend
// pipeline: seven register stages, the last of them the output register
// throughput: one item per cycle while in_stall is low; each stage has its own valid bit, so empty
// stages fill even while the output register is stalled
// reset: arst_n clears all valid bits and all configuration registers to zero
module rounded_rect_aa_pixel_shader (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            in_valid,
	output logic                            in_stall,
	input  logic [rra_pkg::COORD_BITS-1:0]  pixel_x,
	input  logic [rra_pkg::COORD_BITS-1:0]  pixel_y,
	output logic                            out_valid,
	input  logic                            out_stall,
	output logic                            draw,
	output logic [rra_pkg::RGB_BITS-1:0]    pixel_rgb,
	input  logic                            psel,
	input  logic                            penable,
	input  logic                            pwrite,
	input  logic [rra_pkg::ADDR_BITS-1:0]   paddr,
	input  logic [rra_pkg::DATA_BITS-1:0]   pwdata,
	output logic [rra_pkg::DATA_BITS-1:0]   prdata,
	output logic                            pready
);

	rra_pkg::cfg_t cfg;
	rra_pkg::geo_t geo;
	rra_pkg::shd_t shd;
	logic          geo_en, geo_v;
	logic          cov_en, cov_v;
	logic          bld_en;

	// configuration registers
	rra_cfg u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	// stages 1-2
	rra_geom u_geom (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg      (cfg),
		.in_valid (in_valid),
		.pixel_x  (pixel_x),
		.pixel_y  (pixel_y),
		.en_out   (cov_en),
		.en_in    (geo_en),
		.v_out    (geo_v),
		.geo      (geo)
	);

	// stages 3-5
	rra_cover u_cover (
		.clk    (clk),
		.arst_n (arst_n),
		.radius (cfg.radius),
		.v_in   (geo_v),
		.geo    (geo),
		.en_out (bld_en),
		.en_in  (cov_en),
		.v_out  (cov_v),
		.shd    (shd)
	);

	// stages 6-7
	rra_blend u_blend (
		.clk       (clk),
		.arst_n    (arst_n),
		.fill      (cfg.fill),
		.backdrop  (cfg.backdrop),
		.v_in      (cov_v),
		.shd       (shd),
		.en_out    (!out_stall),
		.en_in     (bld_en),
		.v_out     (out_valid),
		.draw      (draw),
		.pixel_rgb (pixel_rgb)
	);

	assign in_stall = !geo_en;

	// a pixel that is not drawn carries a zero colour
	a_skip_black: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !draw |-> pixel_rgb == '0)
		else $error("undrawn pixel with nonzero colour");

	// the input stalls only when the whole pipe is full behind a stalled output
	a_stall_full: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> out_valid && out_stall && cov_v && geo_v)
		else $error("input stalled with room in the pipe");

	// an item taken, with room downstream on the next cycle, then reaches stage 2
	a_geo_move: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall ##1 cov_en |=> geo_v)
		else $error("accepted item lost in the front stages");

endmodule
